// ===== src/scfcd_pkg.sv =====
// Shared types, constants and the CRC byte update for the sensor frame checker.
`timescale 1ns / 1ps
package scfcd_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int VAL_W   = 13;
	localparam int IDX_W   = 3;

	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

	// Frame positions
	localparam logic [IDX_W-1:0] POS_HUM_HI  = 3'd2;
	localparam logic [IDX_W-1:0] POS_HUM_LO  = 3'd3;
	localparam logic [IDX_W-1:0] POS_TMP_HI  = 3'd4;
	localparam logic [IDX_W-1:0] POS_TMP_LO  = 3'd5;
	localparam logic [IDX_W-1:0] POS_CRC_LO  = 3'd6;
	localparam logic [IDX_W-1:0] POS_CRC_HI  = 3'd7;

	// Divide by ten: (x * 0xCCCD) >> 19 is exact for every 16-bit x
	localparam logic [WORD_W-1:0] DIV10_RECIP = 16'hCCCD;
	localparam int                DIV10_SHIFT = 19;
	localparam int                PROD_W      = 2 * WORD_W;

	typedef struct packed {
		logic              crc_ok;
		logic [WORD_W-1:0] hum_word;
		logic [WORD_W-1:0] tmp_word;
	} frame_rec_t;

	typedef struct packed {
		logic             crc_ok;
		logic [VAL_W-1:0] humidity;
		logic [VAL_W-1:0] temperature;
	} result_t;

	// CRC-16/Modbus update over one byte, LSB first
	function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data);
		logic [WORD_W-1:0] c;
		c = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/scfcd_fifo.sv =====
// Small register-based queue used between the stages and at the result side.
`timescale 1ns / 1ps
module scfcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== src/scfcd_front.sv =====
// Front end: byte position tracking, CRC accumulation and word capture.
`timescale 1ns / 1ps
module scfcd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [scfcd_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        frame_start,
	output logic                        rec_valid,
	output scfcd_pkg::frame_rec_t       rec
);
	import scfcd_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] crc_q;
	logic [WORD_W-1:0] hum_q;
	logic [WORD_W-1:0] tmp_q;
	logic [BYTE_W-1:0] crc_lo_q;
	logic [IDX_W-1:0]  idx;
	logic [WORD_W-1:0] crc_base;
	logic [WORD_W-1:0] crc_next;

	// A start byte forces position zero and a fresh CRC
	assign idx      = frame_start ? '0 : idx_q;
	assign crc_base = frame_start ? CRC_INIT : crc_q;
	assign crc_next = crc_byte(crc_base, rx_byte);

	assign rec_valid    = accept && (idx == POS_CRC_HI);
	assign rec.crc_ok   = (crc_lo_q == crc_base[BYTE_W-1:0]) &&
	                      (rx_byte == crc_base[WORD_W-1:BYTE_W]);
	assign rec.hum_word = hum_q;
	assign rec.tmp_word = tmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (accept) begin
			idx_q <= idx + 1'b1;
			if (idx <= POS_TMP_LO) begin
				crc_q <= crc_next;
			end else if (idx == POS_CRC_HI) begin
				crc_q <= CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_q    <= '0;
			tmp_q    <= '0;
			crc_lo_q <= '0;
		end else if (accept) begin
			case (idx)
				POS_HUM_HI: hum_q[WORD_W-1:BYTE_W] <= rx_byte;
				POS_HUM_LO: hum_q[BYTE_W-1:0]      <= rx_byte;
				POS_TMP_HI: tmp_q[WORD_W-1:BYTE_W] <= rx_byte;
				POS_TMP_LO: tmp_q[BYTE_W-1:0]      <= rx_byte;
				POS_CRC_LO: crc_lo_q               <= rx_byte;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/scfcd_back.sv =====
// Back end: scale captured words by one tenth and gate them on the CRC flag.
`timescale 1ns / 1ps
module scfcd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_empty,
	input  scfcd_pkg::frame_rec_t rec,
	output logic                  rec_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output scfcd_pkg::result_t    res
);
	import scfcd_pkg::*;

	logic              valid_s1;
	result_t           res_s1;
	logic              adv_s1;
	logic              load_s1;
	logic [PROD_W-1:0] hum_prod;
	logic [PROD_W-1:0] tmp_prod;

	assign adv_s1   = valid_s1 && !res_full;
	assign load_s1  = !rec_empty && (!valid_s1 || adv_s1);
	assign rec_pop  = load_s1;
	assign res_push = adv_s1;
	assign res      = res_s1;

	assign hum_prod = {{WORD_W{1'b0}}, rec.hum_word} * {{WORD_W{1'b0}}, DIV10_RECIP};
	assign tmp_prod = {{WORD_W{1'b0}}, rec.tmp_word} * {{WORD_W{1'b0}}, DIV10_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Drop the values of a frame that failed its check
	always_ff @(posedge clk) begin
		if (load_s1) begin
			res_s1.crc_ok      <= rec.crc_ok;
			res_s1.humidity    <= rec.crc_ok ? hum_prod[DIV10_SHIFT +: VAL_W] : '0;
			res_s1.temperature <= rec.crc_ok ? tmp_prod[DIV10_SHIFT +: VAL_W] : '0;
		end
	end

endmodule

// ===== src/sensor_frame_crc_check_decode_unit.sv =====
// Top level of the sensor reply frame checker and decoder.
//
//   Channel   Handshake      Fields                                Direction
//   -------   -------------  ------------------------------------  ---------
//   request   push / full    rx_byte[7:0], frame_start             in
//   result    pop / empty    crc_ok, humidity[12:0], temperature   out
//
// One byte request is taken per cycle whenever full is low; the front end
// updates the CRC-16/Modbus and captures words in that same cycle.
// The eighth byte of a frame queues a frame record; the back end registers
// its result (one multiply by the reciprocal of ten) in its stage register
// once that stage is free, then hands it to the output queue when that queue
// has room, and the result waits there until popped.
// full rises only when the record queue between front and back is full, so
// a stalled consumer backs up through the output queue and the back stage.
// Reset (arst_n low) clears byte position, CRC, captured words and queues.
`timescale 1ns / 1ps
module sensor_frame_crc_check_decode_unit #(
	parameter int REC_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        empty,
	input  logic        pop,
	output logic        crc_ok,
	output logic [12:0] humidity,
	output logic [12:0] temperature
);
	import scfcd_pkg::*;

	logic       accept;
	logic       rec_valid;
	frame_rec_t rec_in;
	frame_rec_t rec_out;
	logic       rec_empty;
	logic       rec_pop;
	logic       res_full;
	logic       res_push;
	result_t    res_in;
	result_t    res_out;

	// Accept a byte only while the record queue has room
	assign accept = push && !full;

	scfcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.rec_valid   (rec_valid),
		.rec         (rec_in)
	);

	// Frame records between front and back
	scfcd_fifo #(
		.WIDTH ($bits(frame_rec_t)),
		.DEPTH (REC_DEPTH)
	) u_rec_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_valid),
		.wdata  (rec_in),
		.full   (full),
		.pop    (rec_pop),
		.rdata  (rec_out),
		.empty  (rec_empty)
	);

	scfcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (rec_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Finished results, oldest on the ports
	scfcd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign crc_ok      = res_out.crc_ok;
	assign humidity    = res_out.humidity;
	assign temperature = res_out.temperature;

endmodule

// ===== sim/sensor_frame_crc_check_decode_unit_tb.sv =====
// Self-checking testbench for the sensor frame checker: random byte requests, predicted results.
`timescale 1ns / 1ps
module sensor_frame_crc_check_decode_unit_tb;
	import scfcd_pkg::*;

	localparam int TARGET_REQUESTS = 1150;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 2000;
	localparam int TAIL_CYCLES     = 8;
	localparam int FRAME_BYTES     = 8;
	localparam logic [WORD_W-1:0] DIVISOR = 16'd10;

	// Kinds of damage applied to a generated frame
	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_LO,
		FRAME_BAD_HI,
		FRAME_BAD_BOTH,
		FRAME_BAD_DATA
	} frame_flaw_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        frame_start;
	logic        empty;
	logic        pop;
	logic        crc_ok;
	logic [12:0] humidity;
	logic [12:0] temperature;

	sensor_frame_crc_check_decode_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.empty      (empty),
		.pop        (pop),
		.crc_ok     (crc_ok),
		.humidity   (humidity),
		.temperature(temperature)
	);

	// Decoder state as the testbench sees it
	logic [IDX_W-1:0]  frame_pos;
	logic [WORD_W-1:0] crc_acc;
	logic [WORD_W-1:0] hum_word;
	logic [WORD_W-1:0] tmp_word;
	logic [BYTE_W-1:0] crc_lo_seen;

	// Readings the block still owes us, oldest first
	result_t pending_readings[$];

	int  mismatches = 0;
	int  requests_sent;
	bit  no_gaps;      // when set, neither side idles
	bit  hold_req;     // ask the receiver for one long hold-off
	bit  hold_active;  // receiver is inside that hold-off

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// CRC-16/Modbus over one byte, bit-serial with the reflected polynomial.
	function automatic logic [WORD_W-1:0] modbus_crc_step(input logic [WORD_W-1:0] acc,
		input logic [BYTE_W-1:0] b);
		logic fb;
		for (int i = 0; i < BYTE_W; i++) begin
			fb  = acc[0] ^ b[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	// Advance the decoder state by one accepted byte; queue a reading on the last byte.
	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic s);
		result_t           r;
		logic              ok;
		logic [WORD_W-1:0] q;
		// A frame start drops whatever partial frame was in progress
		if (s) begin
			frame_pos = '0;
			crc_acc   = CRC_INIT;
		end
		if (frame_pos <= POS_TMP_LO) begin
			crc_acc = modbus_crc_step(crc_acc, b);
		end
		case (frame_pos)
			POS_HUM_HI: hum_word[15:8] = b;
			POS_HUM_LO: hum_word[7:0]  = b;
			POS_TMP_HI: tmp_word[15:8] = b;
			POS_TMP_LO: tmp_word[7:0]  = b;
			POS_CRC_LO: crc_lo_seen    = b;
			POS_CRC_HI: begin
				// CRC travels low byte first; a bad check zeroes both values
				ok       = (crc_lo_seen == crc_acc[7:0]) && (b == crc_acc[15:8]);
				r.crc_ok = ok;
				q        = hum_word / DIVISOR;
				r.humidity = ok ? q[VAL_W-1:0] : '0;
				q        = tmp_word / DIVISOR;
				r.temperature = ok ? q[VAL_W-1:0] : '0;
				pending_readings.push_back(r);
				crc_acc  = CRC_INIT;
			end
			default: ;
		endcase
		// The 3-bit position wraps, so back-to-back frames need no frame start
		frame_pos = frame_pos + 1'b1;
	endtask

	// Offer one byte request; return at the edge that accepts it.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push        <= 1'b1;
		rx_byte     <= b;
		frame_start <= s;
		// Hold the request until full is low at a rising edge
		do begin
			@(posedge clk);
		end while (full);
		decode_byte(b, s);
		requests_sent++;
	endtask

	// Build a frame with the given words, damage it as asked, send its first len bytes.
	task automatic send_frame(input logic [WORD_W-1:0] hum, input logic [WORD_W-1:0] tmp,
		input bit with_start, input frame_flaw_t flaw, input int len);
		logic [BYTE_W-1:0] fb[FRAME_BYTES];
		logic [WORD_W-1:0] c;
		int                k;
		fb[0] = 8'($urandom);
		fb[1] = 8'($urandom);
		fb[2] = hum[15:8];
		fb[3] = hum[7:0];
		fb[4] = tmp[15:8];
		fb[5] = tmp[7:0];
		c = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			c = modbus_crc_step(c, fb[i]);
		end
		fb[6] = c[7:0];
		fb[7] = c[15:8];
		case (flaw)
			FRAME_BAD_LO:   fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
			FRAME_BAD_HI:   fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
			FRAME_BAD_BOTH: begin
				fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
				fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
			end
			FRAME_BAD_DATA: begin
				k     = $urandom_range(0, 5);
				fb[k] = fb[k] ^ (8'd1 << $urandom_range(0, 7));
			end
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			send_byte(fb[i], with_start && (i == 0));
		end
	endtask

	// Lower push and wait until every queued reading has been popped.
	task automatic drain_readings();
		@(negedge clk);
		push <= 1'b0;
		while (pending_readings.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Word values biased toward the extremes now and then.
	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return WORD_W'($urandom);
	endfunction

	// Largest values in both words, then all-zero words back to back with a bad CRC.
	task automatic test_extreme_words();
		send_frame(16'hFFFF, 16'hFFFF, 1'b1, FRAME_GOOD, FRAME_BYTES);
		send_frame(16'h0000, 16'h0000, 1'b0, FRAME_BAD_LO, FRAME_BYTES);
	endtask

	// Bad high CRC byte on a frame sent right after another without a frame start.
	task automatic test_bad_crc_back_to_back();
		send_frame(pick_word(), pick_word(), 1'b0, FRAME_BAD_HI, FRAME_BYTES);
	endtask

	// Abandon a frame partway and restart with a frame start.
	task automatic test_frame_restart();
		send_frame(pick_word(), pick_word(), 1'b1, FRAME_GOOD, 4);
		send_frame(pick_word(), pick_word(), 1'b1, FRAME_GOOD, FRAME_BYTES);
	endtask

	// Hold the receiver off long enough that the block fills and raises full.
	task automatic test_backpressure();
		hold_req = 1'b1;
		// Drop the last request so it is not taken again while waiting
		@(negedge clk);
		push <= 1'b0;
		while (!hold_active) begin
			@(posedge clk);
		end
		hold_req = 1'b0;
		no_gaps = 1'b1;
		for (int f = 0; f < 8; f++) begin
			send_frame(pick_word(), pick_word(), 1'b1, FRAME_GOOD, FRAME_BYTES);
		end
		no_gaps = 1'b0;
	endtask

	// Pause the sender until every reading is out, then carry on.
	task automatic test_pause_and_drain();
		send_frame(pick_word(), pick_word(), 1'b1, FRAME_GOOD, FRAME_BYTES);
		send_frame(pick_word(), pick_word(), 1'b0, FRAME_BAD_DATA, FRAME_BYTES);
		drain_readings();
		send_frame(pick_word(), pick_word(), 1'b1, FRAME_GOOD, FRAME_BYTES);
		send_frame(pick_word(), pick_word(), 1'b1, FRAME_BAD_BOTH, FRAME_BYTES);
	endtask

	// Mostly well-formed frames with random content; the rest damaged, cut short or noise.
	task automatic test_random_frames();
		int          r;
		int          next_toggle;
		frame_flaw_t flaw;
		next_toggle = requests_sent + 100;
		while (requests_sent < TARGET_REQUESTS) begin
			// Switch idling on and off in stretches
			if (requests_sent >= next_toggle) begin
				no_gaps     = ($urandom_range(0, 9) < 3);
				next_toggle = requests_sent + 100;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(pick_word(), pick_word(), ($urandom_range(0, 99) < 85),
					FRAME_GOOD, FRAME_BYTES);
			end else if (r < 82) begin
				flaw = frame_flaw_t'($urandom_range(FRAME_BAD_LO, FRAME_BAD_DATA));
				send_frame(pick_word(), pick_word(), 1'b1, flaw, FRAME_BYTES);
			end else if (r < 90) begin
				send_frame(pick_word(), pick_word(), 1'b1, FRAME_GOOD,
					$urandom_range(1, FRAME_BYTES - 1));
			end else begin
				// Noise bytes, with a frame start scattered in now and then
				repeat ($urandom_range(1, 6)) begin
					send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// Receiver: pop with random gaps; serve one long hold-off on request.
	initial begin
		int pop_wait;
		pop_wait    = 0;
		pop         = 1'b0;
		hold_active = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop         <= 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_active = 1'b0;
			end
			if (pop_wait > 0) begin
				pop <= 1'b0;
				pop_wait--;
			end else begin
				pop      <= 1'b1;
				pop_wait = pick_gap();
			end
		end
	end

	// Compare each popped reading with the oldest one predicted.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: reading popped with none expected: crc_ok %0d hum %0d tmp %0d",
					$time, crc_ok, humidity, temperature);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				if (crc_ok !== want.crc_ok) begin
					$display("%0t: crc_ok expected %0d, got %0d", $time, want.crc_ok, crc_ok);
					mismatches++;
				end
				if (humidity !== want.humidity) begin
					$display("%0t: humidity expected %0d, got %0d",
						$time, want.humidity, humidity);
					mismatches++;
				end
				if (temperature !== want.temperature) begin
					$display("%0t: temperature expected %0d, got %0d",
						$time, want.temperature, temperature);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("sensor_frame_crc_check_decode_unit_tb failed");
		$finish;
	end

	initial begin
		// Drive every input to a known value before reset
		arst_n      = 1'b0;
		push        = 1'b0;
		rx_byte     = '0;
		frame_start = 1'b0;
		requests_sent = 0;
		no_gaps     = 1'b0;
		hold_req    = 1'b0;
		frame_pos   = '0;
		crc_acc     = CRC_INIT;
		hum_word    = '0;
		tmp_word    = '0;
		crc_lo_seen = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_words();
		test_bad_crc_back_to_back();
		test_frame_restart();
		test_backpressure();
		test_pause_and_drain();
		test_random_frames();

		// Let the last readings come out, then allow the pipeline to settle
		drain_readings();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("sensor_frame_crc_check_decode_unit_tb passed");
		end else begin
			$display("sensor_frame_crc_check_decode_unit_tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/scfcd_pkg.sv
src/scfcd_fifo.sv
src/scfcd_front.sv
src/scfcd_back.sv
src/sensor_frame_crc_check_decode_unit.sv
sim/sensor_frame_crc_check_decode_unit_tb.sv
